// ----- rtl/rrts_pkg.sv -----
package rrts_pkg;

  // Width of thread ids on the ports; internal ids may be wider and wrap here
  localparam int ID_W     = 5;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE = 2'd0,
    MODE_YIELD  = 2'd1,
    MODE_EXIT   = 2'd2,
    MODE_JOIN   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_UNKNOWN = 2'd1,
    STATUS_NORUN   = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  // Step commands from the controller to the datapath
  typedef struct packed {
    logic take;     // latch the input word
    logic exec;     // run the operation proper
    logic create2;  // add the second thread of a first create
    logic jfix;     // wake the joiner read from the joiner memory
    logic scan;     // build the successor request vectors
    logic pick;     // select the successor
    logic load;     // load the result word
  } ctl_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic first_create;  // create with an empty table
    logic yield_ok;      // yield with a known running thread
    logic exit_ok;       // exit with a known running thread
    logic out_free;      // result register can take a word this cycle
  } sts_t;

endpackage

// ----- rtl/rrts_ctrl.sv -----
module rrts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rrts_pkg::sts_t sts,
  output rrts_pkg::ctl_t ctl
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_CRE2 = 7'b0000100,
    S_JFIX = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_PICK = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one operation through its steps
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.first_create) begin
          state_nxt = S_CRE2;
        end else if (sts.exit_ok) begin
          state_nxt = S_JFIX;
        end else if (sts.yield_ok) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CRE2: begin
        ctl.create2 = 1'b1;
        state_nxt   = S_FIN;
      end
      S_JFIX: begin
        ctl.jfix  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        ctl.scan  = 1'b1;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        ctl.pick  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hold until the result register is free
        if (sts.out_free) begin
          ctl.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/rrts_dp.sv -----
module rrts_dp #(
  parameter int MAX_THREADS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [rrts_pkg::MODE_W-1:0]     in_mode,
  input  logic [rrts_pkg::ID_W-1:0]       in_target_thread,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [rrts_pkg::ID_W-1:0]       out_running_thread,
  output logic [rrts_pkg::ID_W-1:0]       out_new_thread_id,
  output logic                            out_switched,
  output logic [rrts_pkg::STATUS_W-1:0]   out_status,
  input  rrts_pkg::ctl_t                  ctl,
  output rrts_pkg::sts_t                  sts
);

  localparam int OW  = rrts_pkg::ID_W;
  localparam int IDW = $clog2(MAX_THREADS + 1);
  localparam int IW  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CW  = (IDW > OW) ? IDW : OW;
  localparam logic [IDW-1:0] MAX_ID = IDW'(MAX_THREADS);
  localparam logic [IDW-1:0] ONE_ID = IDW'(1);

  // Latched operation
  rrts_pkg::mode_t   mode_r;
  logic [OW-1:0]     tgt_r;
  logic [IDW-1:0]    before_r;

  // Scheduler state
  logic [MAX_THREADS-1:0] act_r, act_nxt;
  logic [IDW-1:0]         total_r, total_nxt;
  logic [IDW-1:0]         run_r, run_nxt;
  rrts_pkg::status_t      status_r, status_nxt;
  logic [IDW-1:0]         new_id_r, new_id_nxt;

  // Successor search requests
  logic [MAX_THREADS-1:0] hi_req_r, all_req_r;
  logic [MAX_THREADS-1:0] known_mask, hi_mask;
  logic [MAX_THREADS-1:0] hi_low, all_low;
  logic [IDW-1:0]         hi_id, all_id;

  // Joiner memory: one write and one registered read per cycle
  logic [IDW-1:0] jn_mem [MAX_THREADS];
  logic [IDW-1:0] jn_rdata_r;
  logic           jn_we;
  logic [IW-1:0]  jn_waddr;
  logic [IDW-1:0] jn_wdata;

  // Result register
  logic          out_valid_r;
  logic [OW-1:0] out_run_r;
  logic [OW-1:0] out_new_r;
  logic          out_sw_r;
  logic [rrts_pkg::STATUS_W-1:0] out_status_r;

  // Decoded ids and indexes
  logic [IDW-1:0] cur_m1, tot_idx_w, jn_m1;
  logic [CW-1:0]  tgt_ext, tgt_m1;
  logic [IW-1:0]  cur_idx, tgt_idx, jn_idx, tot_idx;
  logic           cur_known, tgt_known, jn_known, table_full, add_thread;

  assign cur_m1    = run_r - ONE_ID;
  assign cur_idx   = cur_m1[IW-1:0];
  assign tgt_ext   = CW'(tgt_r);
  assign tgt_m1    = tgt_ext - CW'(1);
  assign tgt_idx   = tgt_m1[IW-1:0];
  assign jn_m1     = jn_rdata_r - ONE_ID;
  assign jn_idx    = jn_m1[IW-1:0];
  assign tot_idx_w = total_r;
  assign tot_idx   = tot_idx_w[IW-1:0];

  assign cur_known  = (run_r != '0) && (run_r <= total_r);
  assign tgt_known  = (tgt_r != '0) && (tgt_ext <= CW'(total_r));
  assign jn_known   = (jn_rdata_r != '0) && (jn_rdata_r <= total_r);
  assign table_full = (total_r == MAX_ID);

  assign add_thread = ctl.create2 ||
                      (ctl.exec && (mode_r == rrts_pkg::MODE_CREATE) && !table_full);

  assign sts.first_create = (mode_r == rrts_pkg::MODE_CREATE) && (total_r == '0);
  assign sts.yield_ok     = (mode_r == rrts_pkg::MODE_YIELD) && cur_known;
  assign sts.exit_ok      = (mode_r == rrts_pkg::MODE_EXIT) && cur_known;
  assign sts.out_free     = !out_valid_r || !out_stall;

  // Mask ids inside the table and ids after the running one
  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) begin
      known_mask[i] = IDW'(i) < total_r;
      hi_mask[i]    = IDW'(i) >= run_r;
    end
  end

  // Isolate the lowest request and encode it as an id
  assign hi_low  = hi_req_r & (~hi_req_r + MAX_THREADS'(1));
  assign all_low = all_req_r & (~all_req_r + MAX_THREADS'(1));

  always_comb begin
    hi_id  = '0;
    all_id = '0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (hi_low[i]) begin
        hi_id = hi_id | IDW'(i + 1);
      end
      if (all_low[i]) begin
        all_id = all_id | IDW'(i + 1);
      end
    end
  end

  // Apply the step of the current operation
  always_comb begin
    act_nxt    = act_r;
    total_nxt  = total_r;
    run_nxt    = run_r;
    status_nxt = status_r;
    new_id_nxt = new_id_r;
    jn_we      = 1'b0;
    jn_waddr   = tot_idx;
    jn_wdata   = '0;

    if (ctl.take) begin
      status_nxt = rrts_pkg::STATUS_OK;
      new_id_nxt = '0;
    end

    // Add a thread at the end of the table and clear its joiner
    if (add_thread) begin
      act_nxt[tot_idx] = 1'b1;
      total_nxt        = total_r + ONE_ID;
      new_id_nxt       = total_r + ONE_ID;
      jn_we            = 1'b1;
      jn_waddr         = tot_idx;
      jn_wdata         = '0;
    end

    if (ctl.exec) begin
      case (mode_r)
        rrts_pkg::MODE_CREATE: begin
          if (table_full) begin
            status_nxt = rrts_pkg::STATUS_FULL;
          end
        end
        rrts_pkg::MODE_YIELD: begin
          if (!cur_known) begin
            status_nxt = rrts_pkg::STATUS_UNKNOWN;
          end
        end
        rrts_pkg::MODE_EXIT: begin
          if (!cur_known) begin
            status_nxt = rrts_pkg::STATUS_UNKNOWN;
          end else begin
            act_nxt[cur_idx] = 1'b0;
          end
        end
        rrts_pkg::MODE_JOIN: begin
          if (!cur_known || !tgt_known) begin
            status_nxt = rrts_pkg::STATUS_UNKNOWN;
          end else if (act_r[tgt_idx]) begin
            // Block the caller and hand the cpu to the target
            act_nxt[cur_idx] = 1'b0;
            run_nxt          = tgt_ext[IDW-1:0];
            jn_we            = 1'b1;
            jn_waddr         = tgt_idx;
            jn_wdata         = run_r;
          end
        end
        default: status_nxt = status_r;
      endcase
    end

    // Wake the joiner of the exiting thread
    if (ctl.jfix && jn_known) begin
      act_nxt[jn_idx] = 1'b1;
      jn_we           = 1'b1;
      jn_waddr        = cur_idx;
      jn_wdata        = '0;
    end

    // Switch to the first active id after the running one, wrapping around; report NORUN if none is active
    if (ctl.pick) begin
      if (|hi_req_r) begin
        run_nxt = hi_id;
      end else if (|all_req_r) begin
        run_nxt = all_id;
      end else begin
        status_nxt = rrts_pkg::STATUS_NORUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= '0;
      total_r     <= '0;
      run_r       <= ONE_ID;
      out_valid_r <= 1'b0;
    end else begin
      act_r   <= act_nxt;
      total_r <= total_nxt;
      run_r   <= run_nxt;
      if (ctl.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    new_id_r <= new_id_nxt;
    if (ctl.take) begin
      mode_r   <= rrts_pkg::mode_t'(in_mode);
      tgt_r    <= in_target_thread;
      before_r <= run_r;
    end
    if (ctl.scan) begin
      hi_req_r  <= act_r & known_mask & hi_mask;
      all_req_r <= act_r & known_mask;
    end
    if (ctl.load) begin
      out_run_r    <= OW'(run_r);
      out_new_r    <= OW'(new_id_r);
      out_sw_r     <= (run_r != before_r);
      out_status_r <= status_r;
    end
  end

  // Joiner memory ports
  always_ff @(posedge clk) begin
    if (jn_we) begin
      jn_mem[jn_waddr] <= jn_wdata;
    end
    if (ctl.exec) begin
      jn_rdata_r <= jn_mem[cur_idx];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_running_thread = out_run_r;
  assign out_new_thread_id  = out_new_r;
  assign out_switched       = out_sw_r;
  assign out_status         = out_status_r;

endmodule

// ----- rtl/round_robin_thread_scheduler.sv -----
// Round-robin thread scheduler: each word on the input channel is one operation
// (create, yield, exit, join) and produces exactly one result word. Operations run
// one at a time through a step sequencer: create, join and rejected operations run
// exec then fin; a first create adds cre2, a yield scan and pick, an exit jfix, scan
// and pick; fin waits while out_stall holds the result register. The steps come
// from the registered read of the joiner memory and the two-stage successor search
// (request vectors, then lowest-set-bit select). A new word is accepted while
// the previous result still waits to be taken. Ids above 31 wrap in the 5-bit result fields.
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rrts_pkg::MODE_W-1:0]   in_mode,
  input  logic [rrts_pkg::ID_W-1:0]     in_target_thread,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrts_pkg::ID_W-1:0]     out_running_thread,
  output logic [rrts_pkg::ID_W-1:0]     out_new_thread_id,
  output logic                          out_switched,
  output logic [rrts_pkg::STATUS_W-1:0] out_status
);

  rrts_pkg::ctl_t ctl;
  rrts_pkg::sts_t sts;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  rrts_dp #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_mode),
    .in_target_thread   (in_target_thread),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_running_thread (out_running_thread),
    .out_new_thread_id  (out_new_thread_id),
    .out_switched       (out_switched),
    .out_status         (out_status),
    .ctl                (ctl),
    .sts                (sts)
  );

endmodule

// ----- dv/tb_round_robin_thread_scheduler.sv -----
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler;
  import rrts_pkg::*;

  localparam int MAX_THR     = 16;
  localparam int N_DIR       = 19;
  localparam int PHASE_ITEMS = 375;
  localparam int DRAIN_WAIT  = 12;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_ACTIVE  = 2'd1,
    SLOT_BLOCKED = 2'd2,
    SLOT_DEAD    = 2'd3
  } slot_st_t;

  typedef struct packed {
    logic [ID_W-1:0] running;
    logic [ID_W-1:0] new_id;
    logic            switched;
    status_t         status;
  } sched_res_t;

  typedef struct {
    mode_t           mode;
    logic [ID_W-1:0] target;
    int              reps;
    bit              typed;
    sched_res_t      want;
  } dir_row_t;

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode          = MODE_CREATE;
  logic [ID_W-1:0]     in_target_thread = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [ID_W-1:0]     out_running_thread;
  logic [ID_W-1:0]     out_new_thread_id;
  logic                out_switched;
  logic [STATUS_W-1:0] out_status;

  // Scheduler shadow state
  slot_st_t        slot_st     [MAX_THR];
  logic [ID_W-1:0] slot_joiner [MAX_THR];
  logic [ID_W-1:0] thread_count;
  logic [ID_W-1:0] running_id;

  sched_res_t pending_results [$];
  int         mismatches  = 0;
  int         idle_pct    = 0;
  int         stall_pct   = 0;
  int         cycle_count = 0;

  // Directed walk: error codes first, then switching, blocking and a full table
  dir_row_t dir_rows [N_DIR] = '{
    '{MODE_YIELD,  5'd0,  1,  1'b1, '{5'd1, 5'd0, 1'b0, STATUS_UNKNOWN}},
    '{MODE_EXIT,   5'd31, 1,  1'b1, '{5'd1, 5'd0, 1'b0, STATUS_UNKNOWN}},
    '{MODE_JOIN,   5'd1,  1,  1'b1, '{5'd1, 5'd0, 1'b0, STATUS_UNKNOWN}},
    '{MODE_CREATE, 5'd0,  1,  1'b1, '{5'd1, 5'd2, 1'b0, STATUS_OK}},
    '{MODE_CREATE, 5'd21, 1,  1'b1, '{5'd1, 5'd3, 1'b0, STATUS_OK}},
    '{MODE_JOIN,   5'd0,  1,  1'b1, '{5'd1, 5'd0, 1'b0, STATUS_UNKNOWN}},
    '{MODE_JOIN,   5'd31, 1,  1'b1, '{5'd1, 5'd0, 1'b0, STATUS_UNKNOWN}},
    '{MODE_JOIN,   5'd4,  1,  1'b1, '{5'd1, 5'd0, 1'b0, STATUS_UNKNOWN}},
    '{MODE_JOIN,   5'd3,  1,  1'b0, '0},
    '{MODE_YIELD,  5'd0,  1,  1'b0, '0},
    '{MODE_JOIN,   5'd2,  1,  1'b0, '0},
    '{MODE_YIELD,  5'd0,  1,  1'b0, '0},
    '{MODE_JOIN,   5'd1,  1,  1'b0, '0},
    '{MODE_EXIT,   5'd0,  1,  1'b0, '0},
    '{MODE_EXIT,   5'd0,  1,  1'b0, '0},
    '{MODE_YIELD,  5'd0,  1,  1'b0, '0},
    '{MODE_JOIN,   5'd2,  1,  1'b0, '0},
    '{MODE_CREATE, 5'd0,  13, 1'b0, '0},
    '{MODE_CREATE, 5'd9,  1,  1'b1, '{5'd1, 5'd0, 1'b0, STATUS_FULL}}
  };

  round_robin_thread_scheduler #(
    .MAX_THREADS(MAX_THR)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_target_thread   (in_target_thread),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_running_thread (out_running_thread),
    .out_new_thread_id  (out_new_thread_id),
    .out_switched       (out_switched),
    .out_status         (out_status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit is_known(int id);
    return id >= 1 && id <= thread_count;
  endfunction

  function automatic logic [ID_W-1:0] add_thread();
    thread_count                 = thread_count + 1'b1;
    slot_st[thread_count - 1]     = SLOT_ACTIVE;
    slot_joiner[thread_count - 1] = '0;
    return thread_count;
  endfunction

  // Scan ids after the running one in circular order, the running id last
  function automatic status_t move_to_successor();
    int id;
    for (int k = 1; k <= thread_count; k++) begin
      id = ((running_id - 1 + k) % thread_count) + 1;
      if (slot_st[id - 1] == SLOT_ACTIVE) begin
        running_id = ID_W'(id);
        return STATUS_OK;
      end
    end
    return STATUS_NORUN;
  endfunction

  // Apply one operation to the shadow state and return the word it produces
  function automatic sched_res_t schedule_op(mode_t mode, logic [ID_W-1:0] target);
    sched_res_t      res;
    logic [ID_W-1:0] prior;
    logic [ID_W-1:0] joiner;
    int              cur;
    prior      = running_id;
    res.new_id = '0;
    res.status = STATUS_OK;
    case (mode)
      MODE_CREATE: begin
        if (thread_count == 0) begin
          void'(add_thread());
          res.new_id = add_thread();
        end else if (thread_count >= MAX_THR) begin
          res.status = STATUS_FULL;
        end else begin
          res.new_id = add_thread();
        end
      end
      MODE_YIELD: begin
        if (!is_known(running_id)) res.status = STATUS_UNKNOWN;
        else res.status = move_to_successor();
      end
      MODE_EXIT: begin
        if (!is_known(running_id)) begin
          res.status = STATUS_UNKNOWN;
        end else begin
          cur          = running_id - 1;
          joiner       = slot_joiner[cur];
          slot_st[cur] = SLOT_DEAD;
          // wake the joiner before searching, so a self-joined thread can run again
          if (is_known(joiner)) begin
            slot_st[joiner - 1] = SLOT_ACTIVE;
            slot_joiner[cur]    = '0;
          end
          res.status = move_to_successor();
        end
      end
      default: begin
        if (!is_known(running_id) || !is_known(target)) begin
          res.status = STATUS_UNKNOWN;
        end else if (slot_st[target - 1] == SLOT_ACTIVE) begin
          slot_st[running_id - 1] = SLOT_BLOCKED;
          slot_joiner[target - 1] = running_id;
          running_id              = target;
        end
      end
    endcase
    res.running  = running_id;
    res.switched = (running_id != prior);
    return res;
  endfunction

  // Prefer an active thread nobody waits on; otherwise any id
  function automatic logic [ID_W-1:0] pick_join_target();
    logic [ID_W-1:0] t;
    for (int n = 0; n < 8; n++) begin
      t = ID_W'($urandom_range(1, MAX_THR));
      if (slot_st[t - 1] == SLOT_ACTIVE && slot_joiner[t - 1] == '0) return t;
    end
    return ID_W'($urandom_range(31));
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Hold the word until accepted, then record the result it must produce
  task automatic issue_op(mode_t mode, logic [ID_W-1:0] target, bit typed,
                          sched_res_t want);
    sched_res_t pred;
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_target_thread <= target;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = schedule_op(mode, target);
    pending_results.push_back(typed ? want : pred);
  endtask

  // Drop valid for a random number of cycles
  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Random receiver stall
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    sched_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word, running_thread", out_running_thread, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_running_thread !== want.running)
          flag_mismatch("running_thread", out_running_thread, want.running);
        if (out_new_thread_id !== want.new_id)
          flag_mismatch("new_thread_id", out_new_thread_id, want.new_id);
        if (out_switched !== want.switched)
          flag_mismatch("switched", out_switched, want.switched);
        if (out_status !== want.status)
          flag_mismatch("status", out_status, want.status);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL round_robin_thread_scheduler");
    $finish;
  end

  initial begin
    mode_t           m;
    logic [ID_W-1:0] t;
    int              r;
    for (int i = 0; i < MAX_THR; i++) begin
      slot_st[i]     = SLOT_FREE;
      slot_joiner[i] = '0;
    end
    thread_count = '0;
    running_id   = 1;

    // Hold reset, then release
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table back to back
    foreach (dir_rows[i]) begin
      for (int n = 0; n < dir_rows[i].reps; n++)
        issue_op(dir_rows[i].mode, dir_rows[i].target, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 35 : 0;
      stall_pct = (ph == 2) ? 47 : (ph == 3) ? 35 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(99);
        t = ID_W'($urandom_range(31));
        if (r < 4) begin
          m = MODE_CREATE;
        end else if (r < 68) begin
          m = MODE_YIELD;
        end else if (r < 84) begin
          m = MODE_JOIN;
          if ($urandom_range(3) != 0) t = pick_join_target();
        end else begin
          // exit mostly when it wakes a joiner, to keep threads alive longer
          m = MODE_EXIT;
          if (slot_joiner[running_id - 1] == '0 && $urandom_range(2) != 0) m = MODE_YIELD;
        end
        idle_gap();
        issue_op(m, t, 1'b0, '0);
      end
    end

    // Drain outstanding results, then let the block settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS round_robin_thread_scheduler");
    end else begin
      $display("FAIL round_robin_thread_scheduler");
    end
    $finish;
  end

endmodule

// ----- round_robin_thread_scheduler.f -----
rtl/rrts_pkg.sv
rtl/rrts_ctrl.sv
rtl/rrts_dp.sv
rtl/round_robin_thread_scheduler.sv
dv/tb_round_robin_thread_scheduler.sv
